// ----- hdl/address_range_segment_table_assert.svh -----
// Assertion macros for the segment table block.
`ifndef ADDRESS_RANGE_SEGMENT_TABLE_ASSERT_SVH
`define ADDRESS_RANGE_SEGMENT_TABLE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define ARST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ARST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/arst_pkg.sv -----
`default_nettype none
package arst_pkg;

  localparam int MaxSeg = 64;
  localparam int IdxW   = $clog2(MaxSeg);
  localparam int CntW   = $clog2(MaxSeg + 1);
  localparam int PageW  = 20;
  localparam int LenW   = 21;
  localparam int AddrW  = PageW + 2;

  localparam logic [AddrW-1:0] TopPage = AddrW'(1) << PageW;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_ALLOC  = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_GAP = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [PageW-1:0] start;
    logic [LenW-1:0]  length;
    logic [2:0]       prot;
  } seg_entry_t;

  // control from the sequencer to the table
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    seg_entry_t       wdata;
    logic [IdxW-1:0]  raddr;
    logic             cnt_inc;
    logic             cnt_dec;
  } tbl_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_RD, S_ADD_EV, S_INS_CHK, S_INS_RD, S_INS_WR, S_INS_POST,
    S_AL_RD0, S_AL_EV0, S_AL_RDN, S_AL_EV, S_RM_RD, S_RM_SKIP, S_RM_LOOP,
    S_RM_EV, S_DEL_RD, S_DEL_WR, S_DEL_FIN, S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/arst_table.sv -----
`default_nettype none
// Segment storage: one write port, one registered read port, fill count.
module arst_table import arst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire tbl_ctrl_t  ctrl,
  output seg_entry_t      rdata,
  output logic [CntW-1:0] count
);

  seg_entry_t      mem [MaxSeg];
  seg_entry_t      rdata_r;
  logic [CntW-1:0] count_r;

  // memory port
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= ctrl.wdata;
    end
    rdata_r <= mem[ctrl.raddr];
  end

  // number of valid (packed) entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.cnt_inc) begin
      count_r <= count_r + CntW'(1);
    end else if (ctrl.cnt_dec) begin
      count_r <= count_r - CntW'(1);
    end
  end

  assign rdata = rdata_r;
  assign count = count_r;

endmodule
`default_nettype wire

// ----- hdl/address_range_segment_table.sv -----
`default_nettype none
// First-fit page range allocator over an address-sorted segment table.
// Input channel (in_*): one transaction per request: add a segment, allocate
// the first gap that fits, or remove a page range. in_stall is high while a
// request is being worked on; one request is in the block at a time.
// Result channel (out_*): one transaction per request with status and the
// allocated start page. The result sits in an output register; the next
// request may be accepted while it waits, and that request's result then
// waits in the sequencer until out_stall drops.
// Operation: the sequencer walks the table through a single registered-read
// memory port and shifts entries the same way on insert or delete. A remove
// shifts the tail once per deleted entry. A new request is not accepted until
// the previous one has left the sequencer.
// Reset (synchronous, rst_n low) empties the table by clearing the fill
// count; no clearing pass is needed and the block is ready right after.
module address_range_segment_table import arst_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [PageW-1:0] in_page_number,
  input  wire logic [LenW-1:0]  in_page_count,
  input  wire logic [2:0]       in_protection,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_status,
  output logic [PageW-1:0]      out_result_page
);

  state_t            state_r, state_nxt;
  logic [1:0]        type_r, type_nxt;
  logic [AddrW-1:0]  addr_r, addr_nxt;
  logic [AddrW-1:0]  size_r, size_nxt;
  logic [AddrW-1:0]  stop_r, stop_nxt;
  logic [2:0]        prot_r, prot_nxt;
  logic [CntW-1:0]   idx_r, idx_nxt;
  logic [CntW-1:0]   j_r, j_nxt;
  seg_entry_t        cur_r, cur_nxt;
  seg_entry_t        ins_r, ins_nxt;
  logic              post_r, post_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [PageW-1:0]  result_r, result_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [PageW-1:0]  out_page_r, out_page_nxt;

  tbl_ctrl_t         ctrl;
  seg_entry_t        rd;
  logic [CntW-1:0]   seg_count;

  arst_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .rdata (rd),
    .count (seg_count)
  );

  // shared datapath
  logic             in_acc, out_free, full;
  logic [AddrW-1:0] in_page_w, in_cnt_w, room, clamped;
  logic [CntW-1:0]  idx_inc, j_inc, j_dec;
  logic             have_next, fit, prot_eq;
  logic [AddrW-1:0] s_w, l_w, e_w, ce, lim;
  logic             adj, halt, skip, del, front, tail;
  logic [AddrW-1:0] a2, sz2;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (seg_count == CntW'(MaxSeg));
  assign in_page_w = {2'b00, in_page_number};
  assign in_cnt_w  = {1'b0, in_page_count};
  assign room      = TopPage - in_page_w;
  assign clamped   = (in_cnt_w > room) ? room : in_cnt_w;
  assign idx_inc   = idx_r + CntW'(1);
  assign j_inc     = j_r + CntW'(1);
  assign j_dec     = j_r - CntW'(1);

  // allocate: gap after the current entry, zero where the next one overlaps
  assign have_next = idx_inc < seg_count;
  assign s_w       = {2'b00, rd.start};
  assign l_w       = {1'b0, rd.length};
  assign e_w       = s_w + l_w;
  assign ce        = {2'b00, cur_r.start} + {1'b0, cur_r.length};
  assign lim       = have_next ? s_w : TopPage;
  assign fit       = ((lim > ce) ? (lim - ce) : AddrW'(0)) >= size_r;
  assign prot_eq   = (cur_r.prot == prot_r);

  // remove: classify the entry against the remaining range
  assign adj   = s_w > addr_r;
  assign halt  = adj && (s_w > stop_r);
  assign a2    = adj ? s_w : addr_r;
  assign sz2   = adj ? (size_r - (s_w - addr_r)) : size_r;
  assign skip  = (e_w <= a2) && !((s_w == a2) && (l_w == '0));
  assign del   = (s_w == a2) && (l_w <= sz2);
  assign front = (s_w == a2);
  assign tail  = (sz2 + (a2 - s_w)) >= l_w;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_req_type)
            REQ_ADD:    state_nxt = S_ADD_RD;
            REQ_ALLOC:  state_nxt = (seg_count == '0) ? S_DONE : S_AL_RD0;
            REQ_REMOVE: state_nxt = S_RM_RD;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_ADD_RD:   state_nxt = (idx_r == seg_count) ? S_INS_CHK : S_ADD_EV;
      S_ADD_EV:   state_nxt = (s_w <= addr_r) ? S_ADD_RD : S_INS_CHK;
      S_INS_CHK:  state_nxt = full ? S_DONE : S_INS_RD;
      S_INS_RD: begin
        if (j_r == idx_r) begin
          state_nxt = post_r ? S_INS_POST : S_DONE;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR:   state_nxt = S_INS_RD;
      S_INS_POST: state_nxt = S_DONE;
      S_AL_RD0:   state_nxt = S_AL_EV0;
      S_AL_EV0:   state_nxt = S_AL_RDN;
      S_AL_RDN:   state_nxt = S_AL_EV;
      S_AL_EV: begin
        if (fit) begin
          state_nxt = prot_eq ? S_DONE : S_INS_CHK;
        end else begin
          state_nxt = have_next ? S_AL_RDN : S_DONE;
        end
      end
      S_RM_RD:    state_nxt = (idx_r >= seg_count) ? S_DONE : S_RM_SKIP;
      S_RM_SKIP:  state_nxt = (e_w <= addr_r) ? S_RM_RD : S_RM_LOOP;
      S_RM_LOOP: begin
        state_nxt = ((size_r == '0) || (idx_r >= seg_count)) ? S_DONE : S_RM_EV;
      end
      S_RM_EV: begin
        if (halt) begin
          state_nxt = S_DONE;
        end else if (skip) begin
          state_nxt = S_RM_LOOP;
        end else if (del) begin
          state_nxt = S_DEL_RD;
        end else if (front || tail) begin
          state_nxt = S_RM_LOOP;
        end else begin
          state_nxt = S_INS_CHK;
        end
      end
      S_DEL_RD:   state_nxt = (j_inc >= seg_count) ? S_DEL_FIN : S_DEL_WR;
      S_DEL_WR:   state_nxt = S_DEL_RD;
      S_DEL_FIN:  state_nxt = S_RM_LOOP;
      S_DONE:     state_nxt = out_free ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath controls and register updates
  always_comb begin
    ctrl          = '0;
    type_nxt      = type_r;
    addr_nxt      = addr_r;
    size_nxt      = size_r;
    stop_nxt      = stop_r;
    prot_nxt      = prot_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    ins_nxt       = ins_r;
    post_nxt      = post_r;
    status_nxt    = status_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_page_nxt  = out_page_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          type_nxt   = in_req_type;
          addr_nxt   = in_page_w;
          size_nxt   = (in_req_type == REQ_ALLOC) ? in_cnt_w : clamped;
          stop_nxt   = in_page_w + clamped;
          prot_nxt   = in_protection;
          idx_nxt    = '0;
          post_nxt   = 1'b0;
          result_nxt = '0;
          status_nxt = ((in_req_type == REQ_ALLOC) && (seg_count == '0)) ?
                       ST_NO_GAP : ST_OK;
          ins_nxt    = '{start: in_page_number, length: clamped[LenW-1:0],
                         prot: in_protection};
        end
      end
      S_ADD_RD: ctrl.raddr = idx_r[IdxW-1:0];
      S_ADD_EV: begin
        if (s_w <= addr_r) begin
          idx_nxt = idx_inc;
        end
      end
      S_INS_CHK: begin
        j_nxt = seg_count;
        if (full) begin
          status_nxt = (type_r == REQ_REMOVE) ? ST_OK : ST_FULL;
          result_nxt = '0;
        end
      end
      S_INS_RD: begin
        ctrl.raddr = j_dec[IdxW-1:0];
        if (j_r == idx_r) begin
          ctrl.we      = 1'b1;
          ctrl.waddr   = idx_r[IdxW-1:0];
          ctrl.wdata   = ins_r;
          ctrl.cnt_inc = 1'b1;
        end
      end
      S_INS_WR: begin
        ctrl.we    = 1'b1;
        ctrl.waddr = j_r[IdxW-1:0];
        ctrl.wdata = rd;
        j_nxt      = j_dec;
      end
      S_INS_POST: begin
        // split: shorten the first half after the second is in place
        ctrl.we    = 1'b1;
        ctrl.waddr = idx_r[IdxW-1:0] - IdxW'(1);
        ctrl.wdata = cur_r;
      end
      S_AL_RD0: ctrl.raddr = '0;
      S_AL_EV0: cur_nxt = rd;
      S_AL_RDN: ctrl.raddr = idx_inc[IdxW-1:0];
      S_AL_EV: begin
        if (fit) begin
          result_nxt = ce[PageW-1:0];
          status_nxt = ST_OK;
          if (prot_eq) begin
            ctrl.we    = 1'b1;
            ctrl.waddr = idx_r[IdxW-1:0];
            ctrl.wdata = '{start: cur_r.start,
                           length: cur_r.length + size_r[LenW-1:0],
                           prot: cur_r.prot};
          end else begin
            ins_nxt = '{start: ce[PageW-1:0], length: size_r[LenW-1:0],
                        prot: prot_r};
            idx_nxt = idx_inc;
          end
        end else if (have_next) begin
          cur_nxt = rd;
          idx_nxt = idx_inc;
        end else begin
          status_nxt = ST_NO_GAP;
        end
      end
      S_RM_RD: ctrl.raddr = idx_r[IdxW-1:0];
      S_RM_SKIP: begin
        if (e_w <= addr_r) begin
          idx_nxt = idx_inc;
        end
      end
      S_RM_LOOP: ctrl.raddr = idx_r[IdxW-1:0];
      S_RM_EV: begin
        if (!halt) begin
          addr_nxt = a2;
          size_nxt = sz2;
          if (skip) begin
            idx_nxt = idx_inc;
          end else if (del) begin
            addr_nxt = a2 + l_w;
            size_nxt = sz2 - l_w;
            j_nxt    = idx_r;
          end else if (front) begin
            ctrl.we    = 1'b1;
            ctrl.waddr = idx_r[IdxW-1:0];
            ctrl.wdata = '{start: PageW'(s_w + sz2), length: LenW'(l_w - sz2),
                           prot: rd.prot};
            size_nxt   = '0;
            idx_nxt    = idx_inc;
          end else if (tail) begin
            ctrl.we    = 1'b1;
            ctrl.waddr = idx_r[IdxW-1:0];
            ctrl.wdata = '{start: rd.start, length: LenW'(a2 - s_w),
                           prot: rd.prot};
            size_nxt   = sz2 - (e_w - a2);
            addr_nxt   = e_w;
            idx_nxt    = idx_inc;
          end else begin
            ins_nxt  = '{start: stop_r[PageW-1:0], length: LenW'(e_w - stop_r),
                         prot: rd.prot};
            cur_nxt  = '{start: rd.start, length: LenW'(a2 - s_w), prot: rd.prot};
            post_nxt = 1'b1;
            idx_nxt  = idx_inc;
          end
        end
      end
      S_DEL_RD: ctrl.raddr = j_inc[IdxW-1:0];
      S_DEL_WR: begin
        ctrl.we    = 1'b1;
        ctrl.waddr = j_r[IdxW-1:0];
        ctrl.wdata = rd;
        j_nxt      = j_inc;
      end
      S_DEL_FIN: ctrl.cnt_dec = 1'b1;
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_page_nxt   = result_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    type_r       <= type_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
    stop_r       <= stop_nxt;
    prot_r       <= prot_nxt;
    idx_r        <= idx_nxt;
    j_r          <= j_nxt;
    cur_r        <= cur_nxt;
    ins_r        <= ins_nxt;
    post_r       <= post_nxt;
    status_r     <= status_nxt;
    result_r     <= result_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_page = out_page_r;

`include "address_range_segment_table_assert.svh"

  `ARST_ASSERT_IMPL(a_count_bound, 1'b1, seg_count <= CntW'(MaxSeg))
  `ARST_ASSERT_NEXT(a_accept_busy, in_acc, state_r != S_IDLE)
  `ARST_ASSERT_IMPL(a_result_src, out_valid_r && !$past(out_valid_r), $past(state_r) == S_DONE)
  `ARST_ASSERT_IMPL(a_nogap_page, out_valid_r && out_status_r != ST_OK, out_page_r == '0)

endmodule
`default_nettype wire
